// ===== hdl/dq_pkg.sv =====
package dq_pkg;

   localparam int DataWidth     = 32;
   localparam int ModeWidth     = 3;
   localparam int StatusWidth   = 2;
   localparam int CountOutWidth = 5;

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic [ModeWidth-1:0]        mode_type;
   typedef logic [StatusWidth-1:0]      status_type;

   // Operation codes carried in the request item.
   localparam mode_type MODE_PUSH_BACK  = 3'd0;
   localparam mode_type MODE_PUSH_FRONT = 3'd1;
   localparam mode_type MODE_POP_BACK   = 3'd2;
   localparam mode_type MODE_POP_FRONT  = 3'd3;
   localparam mode_type MODE_QUERY      = 3'd4;

   // Result status codes.
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // Per-cell controls: shift towards the front, shift towards the back, or load.
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== hdl/dq_cell.sv =====
module dq_cell (
   input  logic               clock,
   input  dq_pkg::cell_ctrl_type ctrl,
   input  dq_pkg::data_type   push_value,
   input  dq_pkg::data_type   lower_data,
   input  dq_pkg::data_type   upper_data,
   output dq_pkg::data_type   data
);
   import dq_pkg::*;

   data_type data_ff;
   data_type data_in;

   // A load only reaches the cell just above the occupied run, so it never
   // coincides with a shift.
   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = push_value;
      end else if (ctrl.shift_up) begin
         data_in = lower_data;
      end else if (ctrl.shift_down) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Bounded double-ended queue of 32-bit signed values, held in a row of cells.
// Request channel (req_*): each item carries an operation in req_tuser (push
// back, push front, pop back, pop front or query) and a value in req_tdata,
// which is only used by the two push operations.
// Response channel (rsp_*): every request item yields exactly one response
// item with the status, the values at the front and back ends, the count and
// an empty flag, all describing the queue after the operation.
// Cell 0 always holds the back-end value and cell count-1 the front-end value.
// A push at the back shifts the whole row up by one cell; a pop at the back
// shifts it down. A push at the front loads the cell just above the run,
// and a pop at the front only lowers the count.
// Each response is registered on acceptance. One item is taken per cycle
// as long as the response side keeps up; the response register frees in the
// same cycle that its item is taken, so no bubble is inserted.
// When the receiver stalls, the response is held and req_tready falls until
// it is taken. Reset empties the queue and drops any pending response; cell
// contents are not cleared, as an empty queue reports zero at both ends.
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [2:0]  req_tuser,  // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // [1:0] status, [33:2] front_value,
                                   // [65:34] back_value, [70:66] count,
                                   // [71] is_empty
);
   import dq_pkg::*;

   localparam int IndexWidth = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;

   logic       req_accept;
   mode_type   mode;
   data_type   push_value;
   logic       is_full;
   logic       is_zero;
   logic       shift_up;
   logic       shift_down;
   logic       load_front;

   data_type   cell_data [DEPTH];
   logic [IndexWidth-1:0] front_index;
   logic [CountWidth+CountOutWidth-1:0] count_ext;
   data_type   front_value;
   data_type   back_value;

   // The response register is free when empty or when its item leaves now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign mode       = req_tuser;
   assign push_value = data_type'(req_tdata);
   assign is_full    = (count_ff == CountWidth'(DEPTH));
   assign is_zero    = (count_ff == '0);

   always_comb begin
      status_in  = STATUS_OK;
      count_in   = count_ff;
      shift_up   = 1'b0;
      shift_down = 1'b0;
      load_front = 1'b0;
      if (req_accept) begin
         case (mode)
            MODE_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  shift_up = 1'b1;
                  count_in = count_ff + CountWidth'(1);
               end
            end
            MODE_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  load_front = 1'b1;
                  count_in   = count_ff + CountWidth'(1);
               end
            end
            MODE_POP_BACK: begin
               if (is_zero) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  shift_down = 1'b1;
                  count_in   = count_ff - CountWidth'(1);
               end
            end
            MODE_POP_FRONT: begin
               if (is_zero) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CountWidth'(1);
               end
            end
            default: begin
               // Query and unused codes leave the queue untouched.
            end
         endcase
      end
   end

   // The row of cells. Each cell takes from its lower neighbour on a back
   // push and from its upper neighbour on a back pop; cell 0 takes the new
   // value on a push, and the top cell keeps its own contents on a pop.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      data_type      lower_data;
      data_type      upper_data;

      assign ctrl.shift_up   = shift_up;
      assign ctrl.shift_down = shift_down;
      // A front push is only taken below full, so the low index bits suffice.
      assign ctrl.load       = load_front && (count_ff[IndexWidth-1:0] == IndexWidth'(i));

      if (i == 0) begin : g_bottom
         assign lower_data = push_value;
      end else begin : g_lower
         assign lower_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_top
         assign upper_data = cell_data[i];
      end else begin : g_upper
         assign upper_data = cell_data[i+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .push_value (push_value),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid_in = req_accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
      end
   end

   // The cells and the count only change when a new item is accepted, which
   // is also when the response register is reloaded, so the end values can
   // be read straight from the cells while the response waits.
   assign front_index = IndexWidth'(count_ff - CountWidth'(1));
   assign front_value = is_zero ? data_type'(0) : cell_data[front_index];
   assign back_value  = is_zero ? data_type'(0) : cell_data[0];
   assign count_ext   = {{CountOutWidth{1'b0}}, count_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {is_zero, count_ext[CountOutWidth-1:0], back_value, front_value,
                        status_ff};

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("fill count above depth");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_FULL) |-> is_full)
      else $error("full status reported on a queue that is not full");

   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_EMPTY) |-> is_zero)
      else $error("empty status reported on a queue that is not empty");

   a_one_action : assert property (@(posedge clock) disable iff (reset)
      $onehot0({shift_up, shift_down, load_front}))
      else $error("more than one cell action in a cycle");

   a_query_keeps : assert property (@(posedge clock) disable iff (reset)
      req_accept && (mode != MODE_PUSH_BACK) && (mode != MODE_PUSH_FRONT) &&
      (mode != MODE_POP_BACK) && (mode != MODE_POP_FRONT) |=> $stable(count_ff))
      else $error("query changed the fill count");

endmodule
